### design/fmrr_pkg.sv
// Shared types and constants for the framed message receive router.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fmrr_pkg;

  localparam logic [7:0] START_BYTE        = 8'd254;
  localparam logic [7:0] END_BYTE          = 8'd255;
  localparam logic [3:0] BROADCAST_ADDRESS = 4'd15;

  localparam logic [1:0] CFG_NODE_ADDRESS   = 2'd0;
  localparam logic [1:0] CFG_HEARTBEAT_KIND = 2'd1;
  localparam logic [1:0] CFG_RECEIVE_ENABLE = 2'd2;

  typedef enum logic [2:0] {
    ACT_DELIVER   = 3'd0,
    ACT_BROADCAST = 3'd1,
    ACT_FORWARD   = 3'd2,
    ACT_DOWN_BEAT = 3'd3,
    ACT_UP_BEAT   = 3'd4
  } action_e;

  // One completed frame as handed from the deframer to the router.
  typedef struct packed {
    logic [3:0] address;
    logic [3:0] kind;
    logic [7:0] message;
  } frame_t;

  // Routing configuration seen by the router.
  typedef struct packed {
    logic [3:0] node_address;
    logic [3:0] heartbeat_kind;
  } route_cfg_t;

endpackage

### design/fmrr_deframer.sv
// Front end: accepts received bytes and finds four-byte frames.
// Depends on fmrr_pkg; pushes each completed frame into the frame queue.
`timescale 1ns / 1ps

module fmrr_deframer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enable_i,
  input  logic            byte_valid_i,
  input  logic [7:0]      rx_byte_i,
  output logic            push_o,
  output fmrr_pkg::frame_t frame_o
);
  import fmrr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_STARTED = 2'd1,
    PH_COMMAND = 2'd2,
    PH_MESSAGE = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] command_q, command_d;
  logic [7:0] message_q, message_d;
  logic       push_d;
  logic       take;

  assign take = byte_valid_i && enable_i;

  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    message_d = message_q;
    push_d    = 1'b0;
    if (take) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == START_BYTE) phase_d = PH_STARTED;
        end
        PH_STARTED, PH_COMMAND: begin
          // a start or end byte here resynchronises the parser
          if (rx_byte_i == START_BYTE) begin
            phase_d = PH_STARTED;
          end else if (rx_byte_i == END_BYTE) begin
            phase_d = PH_HUNT;
          end else if (phase_q == PH_STARTED) begin
            command_d = rx_byte_i;
            phase_d   = PH_COMMAND;
          end else begin
            message_d = rx_byte_i;
            phase_d   = PH_MESSAGE;
          end
        end
        PH_MESSAGE: begin
          // consume the byte either way; drop the frame on a bad end byte
          phase_d = PH_HUNT;
          push_d  = (rx_byte_i == END_BYTE);
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    command_q <= command_d;
    message_q <= message_d;
  end

  assign push_o          = push_d;
  assign frame_o.address = command_q[7:4];
  assign frame_o.kind    = command_q[3:0];
  assign frame_o.message = message_q;

  a_push_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (take && phase_q == PH_MESSAGE && rx_byte_i == END_BYTE))
    else $error("frame pushed without a closing end byte");

  a_message_below_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MESSAGE) |-> (message_q < START_BYTE && command_q < START_BYTE))
    else $error("held frame bytes hold a framing code");

  a_hunt_after_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && phase_q == PH_MESSAGE) |=> (phase_q == PH_HUNT))
    else $error("parser did not return to hunting after a frame");

endmodule

### design/fmrr_fifo.sv
// Short frame queue between the deframer and the router.
// Depends on fmrr_pkg for the frame type; depth set by the Depth parameter.
`timescale 1ns / 1ps

module fmrr_fifo #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fmrr_pkg::frame_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output fmrr_pkg::frame_t pop_data_o
);
  import fmrr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o = mem_q[rd_ptr_q];

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("frame pushed into a full queue");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

### design/fmrr_router.sv
// Back end: pops frames from the queue, routes them, holds the result register.
// Depends on fmrr_pkg for the frame, configuration and action types.
`timescale 1ns / 1ps

module fmrr_router (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmrr_pkg::route_cfg_t cfg_i,
  input  logic                 frame_valid_i,
  input  fmrr_pkg::frame_t     frame_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           action_o,
  output fmrr_pkg::frame_t     frame_o
);
  import fmrr_pkg::*;

  logic    out_valid_q, out_valid_d;
  action_e action_q, action_d;
  frame_t  frame_q;
  logic    has_result;
  logic    load;

  always_comb begin
    has_result = 1'b1;
    action_d   = ACT_FORWARD;
    if (frame_i.address == BROADCAST_ADDRESS) begin
      action_d = ACT_BROADCAST;
    end else if (frame_i.address == cfg_i.node_address) begin
      action_d = ACT_DELIVER;
    end else if (frame_i.kind == cfg_i.heartbeat_kind) begin
      // heartbeats for another node only refresh on messages 0 and 1
      if (frame_i.message == 8'd0) begin
        action_d = ACT_DOWN_BEAT;
      end else if (frame_i.message == 8'd1) begin
        action_d = ACT_UP_BEAT;
      end else begin
        has_result = 1'b0;
      end
    end
  end

  // Advance whenever the result register is empty or being drained.
  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = frame_valid_i && load;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = frame_valid_i && has_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      action_q <= action_d;
      frame_q  <= frame_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign frame_o     = frame_q;

  a_action_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o <= 3'd4))
    else $error("result carries an undefined action");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && has_result) |=> out_valid_o)
    else $error("routed frame lost from the result register");

  a_message_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_o.message < START_BYTE))
    else $error("result message holds a framing code");

endmodule

### design/framed_message_receive_router.sv
// Top level of the framed message receive router.
// Depends on fmrr_pkg, fmrr_deframer, fmrr_fifo and fmrr_router.
//
// Usage:
//   Bytes arrive on the input channel (in_valid_i / in_ready_o, rx_byte_i).
//   Frames are 254, command, message, 255. Each complete frame gives at most
//   one result transaction on the output channel (out_valid_o / out_ready_i)
//   carrying action_o, frame_address_o, frame_kind_o and frame_message_o.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i:
//   index 0 node address, 1 heartbeat type, 2 receive enable; other indexes
//   are ignored. Write only while the block is idle.
// Timing:
//   One byte is accepted per cycle while the queue is not full. After the end
//   byte is accepted, the frame enters the queue at that edge and moves into
//   the router's result register once that register is empty or being drained.
//   The queue of FifoDepth frames between deframer and router only absorbs
//   output stalls; the deframer stalls only when that queue is full.
// Reset:
//   Parser returns to hunting for a start byte, queue and result register
//   are emptied, all configuration registers read zero (receive disabled).
// Stall:
//   A held result keeps its value; frames collect in the queue until it
//   fills, after which in_ready_o drops.
`timescale 1ns / 1ps

module framed_message_receive_router #(
  parameter int FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] action_o,
  output logic [3:0] frame_address_o,
  output logic [3:0] frame_kind_o,
  output logic [7:0] frame_message_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i
);
  import fmrr_pkg::*;

  logic       [3:0] node_address_q;
  logic       [3:0] heartbeat_kind_q;
  logic             receive_enable_q;
  route_cfg_t       route_cfg;
  logic             push;
  frame_t           push_frame;
  logic             queue_full;
  logic             queue_valid;
  logic             pop;
  frame_t           pop_frame;
  frame_t           out_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q   <= '0;
      heartbeat_kind_q <= '0;
      receive_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NODE_ADDRESS:   node_address_q   <= cfg_data_i;
        CFG_HEARTBEAT_KIND: heartbeat_kind_q <= cfg_data_i;
        CFG_RECEIVE_ENABLE: receive_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign route_cfg.node_address   = node_address_q;
  assign route_cfg.heartbeat_kind = heartbeat_kind_q;

  assign in_ready_o = !queue_full;

  fmrr_deframer u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (receive_enable_q),
    .byte_valid_i (in_valid_i && in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push),
    .frame_o      (push_frame)
  );

  fmrr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_frame),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_frame)
  );

  fmrr_router u_router (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (route_cfg),
    .frame_valid_i (queue_valid),
    .frame_i       (pop_frame),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .frame_o       (out_frame)
  );

  assign frame_address_o = out_frame.address;
  assign frame_kind_o    = out_frame.kind;
  assign frame_message_o = out_frame.message;

endmodule

### bench/tb_top.sv
// Self-checking bench for framed_message_receive_router: byte driver, result
// monitor and a frame predictor that tracks the deframer and routing rules.
// Depends on fmrr_pkg and the framed_message_receive_router RTL.
`timescale 1ns / 1ps

module tb_top;
  import fmrr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHoldCycles = 400;

  typedef enum logic [1:0] {
    PH_HUNT, PH_START, PH_COMMAND, PH_MESSAGE
  } rx_phase_e;

  typedef struct {
    action_e    act;
    logic [3:0] addr;
    logic [3:0] kind;
    logic [7:0] msg;
  } routed_frame_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] action_o;
  logic [3:0] frame_address_o;
  logic [3:0] frame_kind_o;
  logic [7:0] frame_message_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = 2'd0;
  logic [3:0] cfg_data_i = 4'd0;

  // Bench copy of the configuration and of the parser state
  logic [3:0] node_addr_cfg = 4'd0;
  logic [3:0] beat_kind_cfg = 4'd0;
  logic       rx_enabled = 1'b0;
  rx_phase_e  rx_phase = PH_HUNT;
  logic [7:0] seen_command = 8'd0;
  logic [7:0] seen_message = 8'd0;

  logic [7:0]    byte_backlog[$];
  routed_frame_t routed_q[$];

  logic byte_taken = 1'b0;
  logic calm = 1'b0;
  logic long_hold_req = 1'b0;
  int   errors = 0;
  int   cycle_count = 0;

  framed_message_receive_router i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .frame_address_o(frame_address_o),
    .frame_kind_o   (frame_kind_o),
    .frame_message_o(frame_message_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Advance the parser copy by one accepted byte and queue any routed frame.
  task automatic deframe_byte(input logic [7:0] b);
    routed_frame_t f;
    logic          keep;
    if (!rx_enabled) return;
    case (rx_phase)
      PH_HUNT: begin
        if (b == START_BYTE) rx_phase = PH_START;
      end
      PH_START, PH_COMMAND: begin
        if (b == START_BYTE) begin
          rx_phase = PH_START;
        end else if (b == END_BYTE) begin
          rx_phase = PH_HUNT;
        end else if (rx_phase == PH_START) begin
          seen_command = b;
          rx_phase = PH_COMMAND;
        end else begin
          seen_message = b;
          rx_phase = PH_MESSAGE;
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        if (b == END_BYTE) begin
          keep = 1'b1;
          f.addr = seen_command[7:4];
          f.kind = seen_command[3:0];
          f.msg = seen_message;
          if (f.addr == BROADCAST_ADDRESS) begin
            f.act = ACT_BROADCAST;
          end else if (f.addr == node_addr_cfg) begin
            f.act = ACT_DELIVER;
          end else if (f.kind == beat_kind_cfg) begin
            if (f.msg == 8'd0) f.act = ACT_DOWN_BEAT;
            else if (f.msg == 8'd1) f.act = ACT_UP_BEAT;
            else keep = 1'b0;
          end else begin
            f.act = ACT_FORWARD;
          end
          if (keep) routed_q.push_back(f);
        end
      end
    endcase
  endtask

  // Monitor: predict on accepted bytes, check accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    routed_frame_t exp_f;
    if (!rst_ni) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) deframe_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (routed_q.size() == 0) begin
          $error("unexpected result transaction: action %0d address %0d",
                 action_o, frame_address_o);
          errors++;
        end else begin
          exp_f = routed_q.pop_front();
          if (action_o !== exp_f.act) begin
            $error("action: expected %0d, got %0d", exp_f.act, action_o);
            errors++;
          end
          if (frame_address_o !== exp_f.addr) begin
            $error("frame_address: expected %0d, got %0d", exp_f.addr, frame_address_o);
            errors++;
          end
          if (frame_kind_o !== exp_f.kind) begin
            $error("frame_kind: expected %0d, got %0d", exp_f.kind, frame_kind_o);
            errors++;
          end
          if (frame_message_o !== exp_f.msg) begin
            $error("frame_message: expected %0d, got %0d", exp_f.msg, frame_message_o);
            errors++;
          end
        end
      end
    end
  end

  // Byte driver: hold the payload until accepted, then advance
  always @(negedge clk_i) begin
    int src_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else if (!(in_valid_i && !byte_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_backlog.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        rx_byte_i <= byte_backlog.pop_front();
      end
    end
  end

  // Result sink: random back-pressure plus one long hold-off
  always @(negedge clk_i) begin
    int sink_gap;
    int hold_left;
    bit hold_done;
    if (long_hold_req && !hold_done) begin
      hold_left = LongHoldCycles;
      hold_done = 1'b1;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 19) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NODE_ADDRESS:   node_addr_cfg = val;
      CFG_HEARTBEAT_KIND: beat_kind_cfg = val;
      CFG_RECEIVE_ENABLE: rx_enabled = val[0];
      default: ;
    endcase
  endtask

  task automatic push_frame(input logic [7:0] command, input logic [7:0] message);
    byte_backlog.push_back(START_BYTE);
    byte_backlog.push_back(command);
    byte_backlog.push_back(message);
    byte_backlog.push_back(END_BYTE);
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames
  task automatic queue_traffic(input int n_bytes);
    int         sel;
    logic [3:0] addr;
    logic [3:0] kind;
    logic [7:0] msg;
    while (n_bytes > 0) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: addr = node_addr_cfg;
        1: addr = BROADCAST_ADDRESS;
        default: addr = 4'($urandom_range(0, 15));
      endcase
      kind = ($urandom_range(0, 1) == 0) ? beat_kind_cfg : 4'($urandom_range(0, 15));
      msg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 253));
      if (sel < 75) begin
        push_frame({addr, kind}, msg);
        n_bytes -= 4;
      end else if (sel < 85) begin
        byte_backlog.push_back(8'($urandom_range(0, 255)));
        n_bytes -= 1;
      end else begin
        byte_backlog.push_back(START_BYTE);
        case ($urandom_range(0, 2))
          0: begin
            byte_backlog.push_back($urandom_range(0, 1) ? START_BYTE : END_BYTE);
            n_bytes -= 2;
          end
          1: begin
            byte_backlog.push_back({addr, kind});
            byte_backlog.push_back($urandom_range(0, 1) ? START_BYTE : END_BYTE);
            n_bytes -= 3;
          end
          default: begin
            byte_backlog.push_back({addr, kind});
            byte_backlog.push_back(msg);
            byte_backlog.push_back($urandom_range(0, 1) ? START_BYTE
                                                        : 8'($urandom_range(0, 253)));
            n_bytes -= 4;
          end
        endcase
      end
    end
  endtask

  // Wait until every byte is taken and every result has arrived, then let
  // the pipeline settle before anything touches the registers.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (byte_backlog.size() != 0 || in_valid_i || routed_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [3:0] node, input logic [3:0] kind,
                           input logic en, input int n_bytes);
    write_reg(CFG_NODE_ADDRESS, node);
    write_reg(CFG_HEARTBEAT_KIND, kind);
    write_reg(CFG_RECEIVE_ENABLE, {3'b000, en});
    queue_traffic(n_bytes);
    wait_idle();
  endtask

  initial begin
    int settle;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Receive disabled after reset: the frame must vanish
    push_frame(8'h05, 8'h00);
    wait_idle();

    write_reg(CFG_RECEIVE_ENABLE, 4'd1);
    // hunting noise, start where a command is due, deliver
    byte_backlog = {8'h00, 8'hFF, START_BYTE, START_BYTE, 8'h05, 8'h00, END_BYTE};
    // end byte where a command is due
    byte_backlog.push_back(START_BYTE);
    byte_backlog.push_back(END_BYTE);
    // start byte where a message is due, then a broadcast with the top message
    byte_backlog.push_back(START_BYTE);
    byte_backlog.push_back(8'h92);
    push_frame(8'hF2, 8'hFD);
    // heartbeats to another node: down, up and ignored message
    push_frame(8'h90, 8'h00);
    push_frame(8'h90, 8'h01);
    push_frame(8'h90, 8'h02);
    // bad end byte that looks like a start: the tail must not form a frame
    byte_backlog = {byte_backlog, START_BYTE, 8'h90, 8'h02, START_BYTE, 8'h47, 8'h4D, END_BYTE};
    // end byte where a message is due, then a plain forward
    byte_backlog = {byte_backlog, START_BYTE, 8'h90, END_BYTE};
    push_frame(8'h47, 8'h4D);
    wait_idle();

    run_phase(4'd14, 4'd15, 1'b1, 150);
    run_phase(4'd15, 4'd0, 1'b1, 150);
    run_phase(4'd3, 4'd3, 1'b0, 20);
    run_phase(4'd3, 4'd3, 1'b1, 150);

    // long stall on the result side while bytes keep coming
    long_hold_req = 1'b1;
    run_phase(4'd7, 4'd12, 1'b1, 200);

    repeat (3) begin
      run_phase(4'($urandom_range(0, 14)), 4'($urandom_range(0, 15)), 1'b1, 130);
    end

    // last stretch with no idling on either side
    calm = 1'b1;
    write_reg(CFG_NODE_ADDRESS, 4'($urandom_range(0, 14)));
    write_reg(CFG_HEARTBEAT_KIND, 4'($urandom_range(0, 15)));
    queue_traffic(150);
    do begin
      @(posedge clk_i);
      #1;
    end while (byte_backlog.size() != 0 || in_valid_i);
    settle = 0;
    while (routed_q.size() != 0 && settle < 1000) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (10) @(posedge clk_i);
    if (routed_q.size() != 0) begin
      $error("%0d expected results never arrived", routed_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
design/fmrr_pkg.sv
design/fmrr_deframer.sv
design/fmrr_fifo.sv
design/fmrr_router.sv
design/framed_message_receive_router.sv
bench/tb_top.sv
